// File: hw/rtl/tsd_pkg.sv
package tsd_pkg;

    localparam int unsigned DELAY_W = 16;
    localparam int unsigned TEMP_W  = 10;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CIDX_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_REPLY   = 2'd1,
        OP_CANCEL  = 2'd2
    } t_op;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DELAY   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FLOOR   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CEILING = 2'd2;

    localparam logic [DELAY_W-1:0]       DELAY_RST   = 16'd60;
    localparam logic signed [TEMP_W-1:0] FLOOR_RST   = -10'sd50;
    localparam logic signed [TEMP_W-1:0] CEILING_RST = 10'sd200;

    typedef struct packed {
        logic [DELAY_W-1:0]       delay;
        logic signed [TEMP_W-1:0] floor;
        logic signed [TEMP_W-1:0] ceiling;
    } t_cfg;

endpackage

// File: hw/rtl/tsd_cfg_regs.sv
module tsd_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tsd_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    output tsd_pkg::t_cfg              o_cfg
);
    import tsd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DELAY:   n_cfg.delay   = i_cfg_data[DELAY_W-1:0];
                CFG_FLOOR:   n_cfg.floor   = $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_CEILING: n_cfg.ceiling = $signed(i_cfg_data[TEMP_W-1:0]);
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay   <= DELAY_RST;
            r_cfg.floor   <= FLOOR_RST;
            r_cfg.ceiling <= CEILING_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: hw/rtl/tsd_in_stage.sv
module tsd_in_stage #(
    parameter int unsigned DW = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [DW-1:0]            i_data,
    input  logic [tsd_pkg::OP_W-1:0] i_user,
    input  logic                     i_adv,
    output logic                     o_valid,
    output logic [DW-1:0]            o_data,
    output logic [tsd_pkg::OP_W-1:0] o_user
);
    import tsd_pkg::*;

    logic            r_valid;
    logic [DW-1:0]   r_data;
    logic [OP_W-1:0] r_user;
    logic            w_load;

    // take a new word when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_adv;
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
            r_user <= i_user;
        end
    end

endmodule

// File: hw/rtl/tsd_core.sv
module tsd_core #(
    parameter int unsigned STATUS_BITS = 3,
    parameter int unsigned TIME_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tsd_pkg::t_cfg                     i_cfg,
    input  logic                              i_adv,
    input  logic [tsd_pkg::OP_W-1:0]          i_op,
    input  logic                              i_start_ok,
    input  logic                              i_read_ok,
    input  logic [STATUS_BITS-1:0]            i_status,
    input  logic signed [tsd_pkg::TEMP_W-1:0] i_reading,
    input  logic [TIME_BITS-1:0]              i_now,
    output logic                              o_notify,
    output logic [STATUS_BITS-1:0]            o_status,
    output logic signed [tsd_pkg::TEMP_W-1:0] o_temp,
    output logic                              o_temp_valid,
    output logic                              o_in_trans,
    output logic                              o_pending
);
    import tsd_pkg::*;

    logic [STATUS_BITS-1:0]   r_cur,   n_cur;
    logic [STATUS_BITS-1:0]   r_cand,  n_cand;
    logic [TIME_BITS-1:0]     r_start, n_start;
    logic                     r_trans, n_trans;
    logic signed [TEMP_W-1:0] r_temp,  n_temp;
    logic                     r_tval,  n_tval;
    logic                     r_pend,  n_pend;

    logic                 w_reply;
    logic                 w_in_win;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_expired;

    assign w_in_win  = (i_reading >= i_cfg.floor) && (i_reading <= i_cfg.ceiling);
    assign w_elapsed = i_now - r_start;
    assign w_expired = (i_now > r_start) &&
                       (w_elapsed > {{(TIME_BITS-DELAY_W){1'b0}}, i_cfg.delay});

    always_comb begin
        n_cur   = r_cur;
        n_cand  = r_cand;
        n_start = r_start;
        n_trans = r_trans;
        n_temp  = r_temp;
        n_tval  = r_tval;
        n_pend  = r_pend;
        w_reply = 1'b0;

        case (i_op)
            OP_REQUEST: begin
                if (!r_pend) begin
                    n_pend = 1'b1;
                    // a failed start completes right away as a reply
                    w_reply = !i_start_ok;
                end
            end
            OP_REPLY:  w_reply = r_pend;
            OP_CANCEL: n_pend = 1'b0;
            default:   w_reply = 1'b0;
        endcase

        if (w_reply) begin
            n_pend = 1'b0;
            if (i_read_ok && w_in_win) begin
                n_temp = i_reading;
                n_tval = 1'b1;
                if (i_status == r_cur) begin
                    n_cand  = i_status;
                    n_start = '0;
                    n_trans = 1'b0;
                end else if (!r_trans || (r_cand != i_status)) begin
                    n_cand  = i_status;
                    n_start = i_now;
                    n_trans = 1'b1;
                end else if (w_expired) begin
                    n_cur   = i_status;
                    n_cand  = i_status;
                    n_start = '0;
                    n_trans = 1'b0;
                end
            end
        end
    end

    assign o_notify     = w_reply;
    assign o_status     = n_cur;
    assign o_temp       = n_temp;
    assign o_temp_valid = n_tval;
    assign o_in_trans   = n_trans;
    assign o_pending    = n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_cand  <= '0;
            r_start <= '0;
            r_trans <= 1'b0;
            r_temp  <= '0;
            r_tval  <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_adv) begin
            r_cur   <= n_cur;
            r_cand  <= n_cand;
            r_start <= n_start;
            r_trans <= n_trans;
            r_temp  <= n_temp;
            r_tval  <= n_tval;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: hw/rtl/tsd_out_stage.sv
module tsd_out_stage #(
    parameter int unsigned DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [DW-1:0] i_data,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    output logic          o_free
);
    logic          r_valid;
    logic [DW-1:0] r_data;

    // free when empty or when the held word is taken this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

// File: hw/rtl/thermal_status_debouncer_top.sv
// An accepted input word sits in the input register, goes through the
// combinational state update and waits in the result register for m_axis.
// Throughput: 1 word per cycle while m_axis does not stall.
// Reset: synchronous, active low; clears status, transition, cached temperature
// and pending mark, and loads the configuration defaults (delay 60, -50..200 C).
module thermal_status_debouncer_top #(
    parameter int unsigned STATUS_BITS = 3,
    parameter int unsigned TIME_BITS   = 32,
    localparam int unsigned IN_DW  = ((2 + STATUS_BITS + 10 + TIME_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_DW = ((4 + STATUS_BITS + 10 + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // start_ok, read_ok, sensor_status, reading, now_seconds, zero pad
    input  logic [IN_DW-1:0]           s_axis_tdata,
    // operation
    input  logic [tsd_pkg::OP_W-1:0]   s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // notify, accepted_status, cached_temp, temp_valid, in_transition,
    // pending_out, zero pad
    output logic [OUT_DW-1:0]          m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tsd_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [15:0]                i_cfg_data
);
    import tsd_pkg::*;

    localparam int unsigned ST_LO  = 2;
    localparam int unsigned RD_LO  = ST_LO + STATUS_BITS;
    localparam int unsigned NOW_LO = RD_LO + TEMP_W;
    localparam int unsigned RES_W  = 4 + STATUS_BITS + TEMP_W;

    t_cfg                     w_cfg;
    logic                     w_in_valid;
    logic [IN_DW-1:0]         w_in_data;
    logic [OP_W-1:0]          w_in_user;
    logic                     w_out_free;
    logic                     w_adv;
    logic                     w_notify;
    logic [STATUS_BITS-1:0]   w_status;
    logic signed [TEMP_W-1:0] w_temp;
    logic                     w_tval;
    logic                     w_trans;
    logic                     w_pend;
    logic [OUT_DW-1:0]        w_res;

    assign w_adv = w_in_valid && w_out_free;

    tsd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tsd_in_stage #(.DW(IN_DW)) u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_data  (w_in_data),
        .o_user  (w_in_user)
    );

    tsd_core #(
        .STATUS_BITS (STATUS_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_adv        (w_adv),
        .i_op         (w_in_user),
        .i_start_ok   (w_in_data[0]),
        .i_read_ok    (w_in_data[1]),
        .i_status     (w_in_data[ST_LO +: STATUS_BITS]),
        .i_reading    ($signed(w_in_data[RD_LO +: TEMP_W])),
        .i_now        (w_in_data[NOW_LO +: TIME_BITS]),
        .o_notify     (w_notify),
        .o_status     (w_status),
        .o_temp       (w_temp),
        .o_temp_valid (w_tval),
        .o_in_trans   (w_trans),
        .o_pending    (w_pend)
    );

    assign w_res = {{(OUT_DW-RES_W){1'b0}}, w_pend, w_trans, w_tval, w_temp,
                    w_status, w_notify};

    tsd_out_stage #(.DW(OUT_DW)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_data  (w_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_free  (w_out_free)
    );

endmodule

// File: test/tb_thermal_status_debouncer_top.sv
`timescale 1ns / 100ps

module tb_thermal_status_debouncer_top;
    import tsd_pkg::*;

    localparam int unsigned IN_DW  = 48;
    localparam int unsigned OUT_DW = 24;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned PRINT_LIMIT    = 60;
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_NONE  = 2'd3;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic                     start_ok;
        logic                     read_ok;
        logic [2:0]               status;
        logic signed [TEMP_W-1:0] reading;
        logic [31:0]              now;
    } t_sensor_word;

    typedef struct {
        logic                     notify;
        logic [2:0]               accepted;
        logic signed [TEMP_W-1:0] temp;
        logic                     temp_valid;
        logic                     in_trans;
        logic                     pending;
    } t_status_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DW-1:0]     s_axis_tdata = '0;
    logic [OP_W-1:0]      s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]    m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    thermal_status_debouncer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Predicted block state and configuration
    logic [DELAY_W-1:0]       cfg_delay   = DELAY_RST;
    logic signed [TEMP_W-1:0] cfg_floor   = FLOOR_RST;
    logic signed [TEMP_W-1:0] cfg_ceiling = CEILING_RST;
    logic [2:0]               st_current = '0;
    logic [2:0]               st_candidate = '0;
    logic [31:0]              st_change_start = '0;
    logic                     st_in_trans = 1'b0;
    logic signed [TEMP_W-1:0] st_temp = '0;
    logic                     st_temp_valid = 1'b0;
    logic                     st_pending = 1'b0;

    t_sensor_word sensor_q[$];
    t_status_word status_q[$];
    t_sensor_word cur_word;
    int unsigned  errors = 0;
    int unsigned  results_seen = 0;
    int unsigned  send_gap = 0, send_calm = 0;
    int unsigned  stall_left = 0, stall_calm = 0;
    int unsigned  idle_cycles = 0;

    // generator state
    logic [31:0]  gen_now = 32'd0;
    logic [2:0]   gen_target = 3'd0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s got %0d want %0d", $time, results_seen, what,
                     got, want);
    endtask

    function automatic bit apply_reply(input t_sensor_word w);
        if (!st_pending)
            return 1'b0;
        st_pending = 1'b0;
        if (!w.read_ok)
            return 1'b1;
        if (w.reading < cfg_floor || w.reading > cfg_ceiling)
            return 1'b1;
        st_temp = w.reading;
        st_temp_valid = 1'b1;
        if (w.status == st_current) begin
            st_candidate = w.status;
            st_change_start = '0;
            st_in_trans = 1'b0;
        end else if (!st_in_trans || st_candidate != w.status) begin
            st_candidate = w.status;
            st_change_start = w.now;
            st_in_trans = 1'b1;
        end else if (w.now > st_change_start &&
                     (w.now - st_change_start) > {16'd0, cfg_delay}) begin
            st_current = w.status;
            st_candidate = w.status;
            st_change_start = '0;
            st_in_trans = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void debounce_predict(input t_sensor_word w);
        t_status_word r;
        r.notify = 1'b0;
        if (w.op == OP_REQUEST) begin
            if (!st_pending) begin
                st_pending = 1'b1;
                // a failed start completes at once with this word's reading
                if (!w.start_ok)
                    r.notify = apply_reply(w);
            end
        end else if (w.op == OP_REPLY) begin
            r.notify = apply_reply(w);
        end else if (w.op == OP_CANCEL) begin
            st_pending = 1'b0;
        end
        r.accepted   = st_current;
        r.temp       = st_temp;
        r.temp_valid = st_temp_valid;
        r.in_trans   = st_in_trans;
        r.pending    = st_pending;
        status_q.push_back(r);
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Sensor word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                debounce_predict(cur_word);
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 63) == 0)
                send_calm = 40;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sensor_q.size() != 0) begin
                    cur_word = sensor_q.pop_front();
                    s_axis_tdata <= {1'b0, cur_word.now, cur_word.reading, cur_word.status,
                                     cur_word.read_ok, cur_word.start_ok};
                    s_axis_tuser <= cur_word.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_calm != 0);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_status_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = status_q.pop_front();
                    if (m_axis_tdata[0] !== want.notify)
                        report_mismatch("notify", m_axis_tdata[0], want.notify);
                    if (m_axis_tdata[3:1] !== want.accepted)
                        report_mismatch("accepted_status", m_axis_tdata[3:1], want.accepted);
                    if (m_axis_tdata[13:4] !== want.temp)
                        report_mismatch("cached_temp", $signed(m_axis_tdata[13:4]),
                                        want.temp);
                    if (m_axis_tdata[14] !== want.temp_valid)
                        report_mismatch("temp_valid", m_axis_tdata[14], want.temp_valid);
                    if (m_axis_tdata[15] !== want.in_trans)
                        report_mismatch("in_transition", m_axis_tdata[15], want.in_trans);
                    if (m_axis_tdata[16] !== want.pending)
                        report_mismatch("pending_out", m_axis_tdata[16], want.pending);
                    if (m_axis_tdata[OUT_DW-1:17] !== '0)
                        report_mismatch("pad bits", m_axis_tdata[OUT_DW-1:17], 0);
                end
                results_seen++;
            end
            if (stall_calm > 0)
                stall_calm--;
            else if ($urandom_range(0, 63) == 0)
                stall_calm = 40;
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(stall_calm != 0);
            end
        end
    end

    // Watchdog: any accepted word on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [OP_W-1:0] op, input logic start_ok,
                             input logic read_ok, input logic [2:0] status,
                             input logic signed [TEMP_W-1:0] reading, input logic [31:0] now);
        t_sensor_word w;
        w.op = op;
        w.start_ok = start_ok;
        w.read_ok = read_ok;
        w.status = status;
        w.reading = reading;
        w.now = now;
        sensor_q.push_back(w);
    endtask

    // Request that starts cleanly, then the sensor's reply
    task automatic push_pair(input logic read_ok, input logic [2:0] status,
                             input logic signed [TEMP_W-1:0] reading, input logic [31:0] now);
        logic [31:0] junk;
        junk = $urandom;
        push_word(OP_REQUEST, 1'b1, junk[0], junk[3:1], junk[13:4], $urandom);
        push_word(OP_REPLY, 1'b0, read_ok, status, reading, now);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
        logic [15:0] junk;
        junk = $urandom;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= (idx == CFG_DELAY) ? val[15:0] : {junk[15:10], val[9:0]};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DELAY:   cfg_delay = val[15:0];
            CFG_FLOOR:   cfg_floor = val[9:0];
            CFG_CEILING: cfg_ceiling = val[9:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (sensor_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
            @(negedge i_clk);
        // let the two-stage pipeline drain
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic gen_phase(input int unsigned n);
        int unsigned k, r;
        int lo, hi;
        logic [2:0] st;
        logic signed [TEMP_W-1:0] rd;
        logic [31:0] junk;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                gen_now = gen_now + $urandom_range(0, 3);
            else if (r < 85)
                gen_now = gen_now + $urandom_range(0, 2 * cfg_delay + 4);
            else if (r < 95)
                gen_now = gen_now + $urandom_range(0, 200000);
            else if (r < 98)
                gen_now = gen_now - $urandom_range(1, 50);
            else
                gen_now = $urandom;

            if ($urandom_range(0, 99) < 15)
                gen_target = 3'($urandom_range(0, 7));
            st = ($urandom_range(0, 99) < 75) ? gen_target : 3'($urandom_range(0, 7));

            lo = cfg_floor;
            hi = cfg_ceiling;
            if (lo <= hi && $urandom_range(0, 99) < 85)
                rd = 10'(lo + int'($urandom_range(0, hi - lo)));
            else
                rd = 10'($urandom);

            r = $urandom_range(0, 99);
            junk = $urandom;
            if (r < 70)
                push_pair($urandom_range(0, 9) != 0, st, rd, gen_now);
            else if (r < 80)
                push_word(OP_REQUEST, 1'b0, $urandom_range(0, 9) != 0, st, rd, gen_now);
            else
                push_word(junk[1:0], junk[2], junk[3], junk[6:4], junk[16:7], $urandom);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words at the reset configuration
        push_word(OP_REPLY, 1'b1, 1'b1, 3'd3, 20, 32'd10);      // reply with nothing pending
        push_word(OP_CANCEL, 1'b0, 1'b0, 3'd0, 0, 32'd11);
        push_word(OP_UNUSED, 1'b1, 1'b1, 3'd7, -1, 32'hFFFF_FFFF);
        push_word(OP_REQUEST, 1'b1, 1'b1, 3'd0, 0, 32'd12);
        push_word(OP_REQUEST, 1'b0, 1'b1, 3'd2, 10, 32'd13);     // already pending
        push_word(OP_CANCEL, 1'b1, 1'b1, 3'd1, 1, 32'd13);
        push_word(OP_REQUEST, 1'b0, 1'b0, 3'd4, 10, 32'd14);     // failed start and read
        push_pair(1'b1, 3'd2, 511, 32'd20);                      // above window
        push_pair(1'b1, 3'd2, -512, 32'd21);                     // below window
        push_pair(1'b1, 3'd0, -50, 32'd22);                      // matches accepted status
        push_pair(1'b1, 3'd5, 200, 32'd1000);
        push_pair(1'b1, 3'd5, 0, 32'd999);                       // time goes backwards
        push_pair(1'b1, 3'd6, 1, 32'd1010);                      // new candidate
        push_pair(1'b1, 3'd6, 2, 32'd1070);                      // exactly at the delay
        push_pair(1'b1, 3'd6, 3, 32'd1071);
        push_word(OP_REQUEST, 1'b0, 1'b1, 3'd7, 0, 32'hFFFF_FFFF);
        wait_idle();

        gen_now = 32'd2000;
        gen_phase(95);
        wait_idle();

        write_reg(CFG_DELAY, 0);
        write_reg(CFG_FLOOR, -512);
        write_reg(CFG_CEILING, 511);
        @(negedge i_clk);
        gen_phase(105);
        wait_idle();

        write_reg(CFG_DELAY, 65535);
        write_reg(CFG_FLOOR, 0);
        write_reg(CFG_CEILING, 100);
        @(negedge i_clk);
        gen_phase(105);
        wait_idle();

        // floor above ceiling drops every reading
        write_reg(CFG_DELAY, 5);
        write_reg(CFG_FLOOR, 150);
        write_reg(CFG_CEILING, -150);
        write_reg(CFG_NONE, $urandom_range(0, 65535));
        @(negedge i_clk);
        gen_phase(55);
        wait_idle();

        write_reg(CFG_DELAY, 17);
        write_reg(CFG_FLOOR, -30);
        write_reg(CFG_CEILING, 480);
        @(negedge i_clk);
        gen_phase(105);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (status_q.size() != 0)
            report_mismatch("missing words", 0, status_q.size());
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_cfg_regs.sv
hw/rtl/tsd_in_stage.sv
hw/rtl/tsd_core.sv
hw/rtl/tsd_out_stage.sv
hw/rtl/thermal_status_debouncer_top.sv
test/tb_thermal_status_debouncer_top.sv
